[rtl/aabb_proj_pkg.sv]
// Shared types and constants for the box screen projection core.
// No dependencies.
package aabb_proj_pkg;
	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 240;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int NUM_REGS          = 8;
	localparam int REG_W             = 64;
	localparam int IDX_W             = 3;
	localparam int CFG_IDX_W         = 4;
	localparam int NDC_W             = 42;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
		logic signed [31:0] grow_x;
		logic signed [31:0] grow_y;
		logic signed [31:0] grow_z;
	} box_t;

	typedef struct packed {
		logic signed [31:0] rect_left;
		logic signed [31:0] rect_top;
		logic signed [31:0] rect_right;
		logic signed [31:0] rect_bottom;
		logic signed [31:0] nearest_depth;
		logic               any_visible;
	} rect_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return S32_MAX;
		if (v < -64'sd2147483648) return S32_MIN;
		return v[31:0];
	endfunction
endpackage

[rtl/aabb_proj_if.sv]
// Valid/ready channel carrying one payload struct.
// No dependencies; the payload type is a parameter.
interface aabb_proj_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/aabb_proj_div.sv]
// Pipelined signed restoring divider, one quotient bit per stage, floor result.
// No dependencies.
module aabb_proj_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int TW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [NW-1:0] num,
	input  logic        [DW-1:0] den,
	input  logic        [TW-1:0] tag_in,
	output logic                 out_valid,
	output logic signed [NW:0]   quo,
	output logic        [TW-1:0] tag_out
);
	// magnitude divide of |num| (or |num|-1 for negatives) then floor fixup
	logic [NW-1:0] q_s   [NW+1];
	logic [DW:0]   r_s   [NW+1];
	logic [DW-1:0] d_s   [NW+1];
	logic          neg_s [NW+1];
	logic [TW-1:0] t_s   [NW+1];
	logic          v_s   [NW+1];
	logic [NW-1:0] mag;

	assign mag = num[NW-1] ? NW'(-(num + NW'(1))) : NW'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0]   <= mag;
			r_s[0]   <= '0;
			d_s[0]   <= den;
			neg_s[0] <= num[NW-1];
			t_s[0]   <= tag_in;
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW:0]   sh;
		logic [DW+1:0] diff;
		assign sh   = {r_s[i][DW-1:0], q_s[i][NW-1]};
		assign diff = {1'b0, sh} - {2'b0, d_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1]   <= {q_s[i][NW-2:0], ~diff[DW+1]};
				r_s[i+1]   <= diff[DW+1] ? sh : diff[DW:0];
				d_s[i+1]   <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				t_s[i+1]   <= t_s[i];
			end
		end
	end

	// negative: floor(n/d) = -(floor((-n-1)/d)) - 1
	assign quo = neg_s[NW] ? -$signed({1'b0, q_s[NW]}) - (NW+1)'(1)
	                       : $signed({1'b0, q_s[NW]});
	assign out_valid = v_s[NW];
	assign tag_out   = t_s[NW];
endmodule

[rtl/aabb_screen_rect_projection_core.sv]
// Box to screen rectangle projection core: top level.
// Depends on aabb_proj_pkg, aabb_proj_if, aabb_proj_div.
//
// Usage: box items arrive on the in channel (valid/ready), one rectangle leaves
// on the out channel per box. The 4x4 matrix is loaded through cfg_we/cfg_idx/
// cfg_data while idle; indexes beyond seven are dropped.
// The eight corners are issued one a cycle, unless the output stalls, into a
// shared matrix-multiply pipeline (3 stages) and two pipelined dividers
// (49 stages); the divide pipeline sets latency. A new box is taken as soon as
// the corner sequencer finishes the last corner of the previous one.
// Reset: clears matrix registers, sequencer and all valid bits.
// Stall: the whole pipeline holds while a finished result waits in the output
// register and the receiver is not ready; nothing is dropped or repeated.
module aabb_screen_rect_projection_core #(
	parameter int SCREEN_WIDTH  = aabb_proj_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = aabb_proj_pkg::SCREEN_HEIGHT_DEF,
	parameter int FRAC_BITS     = aabb_proj_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	aabb_proj_if.sink                        in_ch,
	aabb_proj_if.source                      out_ch,
	input  logic                             cfg_we,
	input  logic [aabb_proj_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [aabb_proj_pkg::REG_W-1:0]  cfg_data
);
	import aabb_proj_pkg::*;

	localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] W_MIN  = (ONE_FX + 64'sd50) / 64'sd100;
	localparam logic signed [63:0] CX = (64'(SCREEN_WIDTH) <<< FRAC_BITS) / 2;
	localparam logic signed [63:0] CY = (64'(SCREEN_HEIGHT) <<< FRAC_BITS) / 2;
	localparam logic signed [NDC_W-1:0] NDC_LIM = NDC_W'(64'sd1 <<< 40);
	localparam int NW = 32 + FRAC_BITS;

	// matrix registers
	logic [REG_W-1:0] mat_q [NUM_REGS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) mat_q[i] <= '0;
		end else if (cfg_we && cfg_idx < CFG_IDX_W'(NUM_REGS)) begin
			mat_q[cfg_idx[IDX_W-1:0]] <= cfg_data;
		end
	end

	logic signed [31:0] m [4][4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			m[r][0] = mat_q[2*r][31:0];
			m[r][1] = mat_q[2*r][63:32];
			m[r][2] = mat_q[2*r+1][31:0];
			m[r][3] = mat_q[2*r+1][63:32];
		end
	end

	logic en;
	logic busy_q;
	logic [2:0] cnt_q;
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];

	// corner sequencer: latch widened box, issue one corner per cycle unless stalled
	assign in_ch.ready = en && (!busy_q || cnt_q == 3'd7);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (en) begin
			if (in_ch.valid && in_ch.ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) busy_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en && in_ch.valid && in_ch.ready) begin
			lo_q[0] <= sat32(64'(in_ch.data.box_min_x) - 64'(in_ch.data.grow_x));
			lo_q[1] <= sat32(64'(in_ch.data.box_min_y) - 64'(in_ch.data.grow_y));
			lo_q[2] <= sat32(64'(in_ch.data.box_min_z) - 64'(in_ch.data.grow_z));
			hi_q[0] <= sat32(64'(in_ch.data.box_max_x) + 64'(in_ch.data.grow_x));
			hi_q[1] <= sat32(64'(in_ch.data.box_max_y) + 64'(in_ch.data.grow_y));
			hi_q[2] <= sat32(64'(in_ch.data.box_max_z) + 64'(in_ch.data.grow_z));
		end
	end

	// stage 1: corner vector
	logic v_s1;
	logic last_s1;
	logic signed [31:0] vec_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= busy_q;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1[0] <= cnt_q[0] ? hi_q[0] : lo_q[0];
			vec_s1[1] <= cnt_q[1] ? hi_q[1] : lo_q[1];
			vec_s1[2] <= cnt_q[2] ? hi_q[2] : lo_q[2];
			last_s1   <= cnt_q == 3'd7;
		end
	end

	// stage 2: products, floored per term; a floored term needs up to 48 bits
	logic v_s2;
	logic last_s2;
	logic signed [47:0] prod_s2 [4][4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			last_s2 <= last_s1;
			for (int r = 0; r < 4; r++) begin
				for (int j = 0; j < 3; j++)
					prod_s2[r][j] <= 48'((64'(m[r][j]) * 64'(vec_s1[j])) >>> FRAC_BITS);
				prod_s2[r][3] <= 48'(m[r][3]);
			end
		end
	end

	// stage 3: row sums and visibility
	logic v_s3;
	logic last_s3;
	logic vis_s3;
	logic signed [31:0] clip_s3 [4];
	logic signed [63:0] acc [4];
	always_comb begin
		for (int r = 0; r < 4; r++)
			acc[r] = 64'(prod_s2[r][0]) + 64'(prod_s2[r][1]) + 64'(prod_s2[r][2])
			       + 64'(prod_s2[r][3]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			last_s3 <= last_s2;
			for (int r = 0; r < 4; r++) clip_s3[r] <= sat32(acc[r]);
			vis_s3 <= 64'(sat32(acc[3])) > W_MIN;
		end
	end

	// dividers: x/w and y/w
	localparam int TW_C = 34;
	logic [TW_C-1:0] tag_in, tag_out;
	logic dv_x, dv_y;
	logic signed [NW:0] qx, qy;
	logic [TW_C-1:0] tag_y_unused;
	assign tag_in = {last_s3, vis_s3, clip_s3[3]};
	aabb_proj_div #(.NW(NW), .DW(32), .TW(TW_C)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(NW'(clip_s3[0]) <<< FRAC_BITS), .den(clip_s3[3]), .tag_in(tag_in),
		.out_valid(dv_x), .quo(qx), .tag_out(tag_out));
	aabb_proj_div #(.NW(NW), .DW(32), .TW(TW_C)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(NW'(clip_s3[1]) <<< FRAC_BITS), .den(clip_s3[3]), .tag_in(tag_in),
		.out_valid(dv_y), .quo(qy), .tag_out(tag_y_unused));

	// stage 4: clamp ndc
	logic v_s4, last_s4, vis_s4;
	logic signed [31:0] w_s4;
	logic signed [NDC_W-1:0] nx_s4, ny_s4;
	function automatic logic signed [NDC_W-1:0] clamp_ndc(input logic signed [NW:0] q);
		if (64'(q) > 64'(NDC_LIM)) return NDC_LIM;
		if (64'(q) < -64'(NDC_LIM)) return -NDC_LIM;
		return NDC_W'(q);
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= dv_x && dv_y;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			{last_s4, vis_s4, w_s4} <= tag_out;
			nx_s4 <= clamp_ndc(qx);
			ny_s4 <= clamp_ndc(qy);
		end
	end

	// stage 5: screen mapping
	logic v_s5, last_s5, vis_s5;
	logic signed [31:0] w_s5, sx_s5, sy_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			last_s5 <= last_s4;
			vis_s5  <= vis_s4;
			w_s5    <= w_s4;
			sx_s5 <= sat32(CX + ((64'(nx_s4) * 64'(SCREEN_WIDTH)) >>> 1));
			sy_s5 <= sat32(CY - ((64'(ny_s4) * 64'(SCREEN_HEIGHT)) >>> 1));
		end
	end

	// reduction across the eight corners
	rect_t acc_q;
	logic  first_q;
	rect_t cur, nxt;
	always_comb begin
		cur = first_q ? rect_t'{S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 1'b0} : acc_q;
		nxt = cur;
		if (vis_s5) begin
			if (sx_s5 < cur.rect_left)     nxt.rect_left = sx_s5;
			if (sx_s5 > cur.rect_right)    nxt.rect_right = sx_s5;
			if (sy_s5 < cur.rect_top)      nxt.rect_top = sy_s5;
			if (sy_s5 > cur.rect_bottom)   nxt.rect_bottom = sy_s5;
			if (w_s5 < cur.nearest_depth)  nxt.nearest_depth = w_s5;
			nxt.any_visible = 1'b1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b1;
		else if (en && v_s5) first_q <= last_s5;
	end
	always_ff @(posedge clk) begin
		if (en && v_s5) acc_q <= nxt;
	end

	// output register; pipeline holds only while it is full and stalled
	logic  ov_q;
	rect_t od_q;
	assign en = !ov_q || out_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (en) ov_q <= v_s5 && last_s5;
	end
	always_ff @(posedge clk) begin
		if (en && v_s5 && last_s5) od_q <= nxt;
	end
	assign out_ch.valid = ov_q;
	assign out_ch.data  = od_q;
endmodule

[rtl/aabb_proj_chk.sv]
// Port-level checker for the projection core, bound to the top level.
// Depends on aabb_proj_pkg and the core's ports.
module aabb_proj_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input aabb_proj_pkg::rect_t        out_data
);
	import aabb_proj_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_none_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.any_visible |-> out_data.rect_left == S32_MAX
		&& out_data.rect_right == S32_MIN && out_data.nearest_depth == S32_MAX)
		else $error("invisible result lacks sentinels");

	a_vis_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.any_visible |-> out_data.rect_left <= out_data.rect_right
		&& out_data.rect_top <= out_data.rect_bottom)
		else $error("visible rectangle inverted");

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("box taken on consecutive cycles");
endmodule

bind aabb_screen_rect_projection_core aabb_proj_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
